[rtl/cutoff_neighbor_pair_finder_core_assert.svh]
// assertion macros shared by the rtl of the neighbor pair finder
`ifndef CUTOFF_NEIGHBOR_PAIR_FINDER_CORE_ASSERT_SVH
`define CUTOFF_NEIGHBOR_PAIR_FINDER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CNPF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cnpf assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define CNPF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cnpf assertion failed");

`endif

[rtl/cnpf_pkg.sv]
// shared constants, codes and types of the neighbor pair finder
`timescale 1ns / 1ps
`default_nettype none

package cnpf_pkg;

  localparam int LEN_W          = 23;
  localparam int MASK_W         = 3;
  localparam int IDX_OUT_W      = 6;
  localparam int CFG_IDX_W      = 3;
  localparam int SQ_W           = 2 * LEN_W;
  localparam int ACC_W          = SQ_W + 2;
  localparam int DEF_MAX_ATOMS  = 64;
  localparam int DEF_COORD_BITS = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_X  = 3'd0,
    REG_BOX_Y  = 3'd1,
    REG_BOX_Z  = 3'd2,
    REG_PMASK  = 3'd3,
    REG_CUTOFF = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CUT,
    ST_RD,
    ST_DIF,
    ST_WRP,
    ST_MAG,
    ST_SQR,
    ST_ACC,
    ST_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic  load_cut;
    logic  clear;
    logic  dif;
    logic  wrp;
    logic  mag;
    logic  sqr;
    logic  acc;
    axis_t axis;
  } dp_ctrl_t;

endpackage

`default_nettype wire

[rtl/cnpf_in_if.sv]
// input channel: one atom per item
`timescale 1ns / 1ps
`default_nettype none

interface cnpf_in_if #(
  parameter int COORD_BITS = cnpf_pkg::DEF_COORD_BITS
);
  logic                         valid;
  logic                         ready;
  logic                         new_frame;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;

  modport source (output valid, new_frame, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, new_frame, pos_x, pos_y, pos_z, output ready);
endinterface

`default_nettype wire

[rtl/cnpf_out_if.sv]
// result channel: pair items and closing items
`timescale 1ns / 1ps
`default_nettype none

interface cnpf_out_if;
  logic                           valid;
  logic                           ready;
  logic                           pair_valid;
  logic [cnpf_pkg::IDX_OUT_W-1:0] lower_index;
  logic [cnpf_pkg::IDX_OUT_W-1:0] upper_index;
  logic                           run_last;
  logic                           atom_dropped;

  modport source (output valid, pair_valid, lower_index, upper_index, run_last,
                  atom_dropped, input ready);
  modport sink   (input valid, pair_valid, lower_index, upper_index, run_last,
                  atom_dropped, output ready);
endinterface

`default_nettype wire

[rtl/cutoff_neighbor_pair_finder_core.sv]
// top level: sequencer, config registers and result register of the pair finder
//
// channel    dir    handshake        payload
// in_chan    in     valid / ready    new_frame, pos_x, pos_y, pos_z
// out_chan   out    valid / ready    pair_valid, lower_index, upper_index, run_last, atom_dropped
// cfg_*      in     cfg_wr_en        cfg_index, cfg_wdata
//
// an atom holds the input until its run closes, while it is compared with every stored atom
// each stored atom takes one memory read, five steps per axis through the
// shared wrap and square unit, and one compare; the cutoff is squared first, once per atom
// a dropped atom goes straight to its closing item; a stalled result register holds back a hit or the close
// reset clears the atom count and config; the atom memory is not cleared
`timescale 1ns / 1ps
`default_nettype none
`include "cutoff_neighbor_pair_finder_core_assert.svh"

module cutoff_neighbor_pair_finder_core #(
  parameter int MAX_ATOMS  = cnpf_pkg::DEF_MAX_ATOMS,
  parameter int COORD_BITS = cnpf_pkg::DEF_COORD_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [cnpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cnpf_pkg::LEN_W-1:0]      cfg_wdata,
  cnpf_in_if.sink                              in_chan,
  cnpf_out_if.source                           out_chan
);

  localparam int IDX_W = $clog2(MAX_ATOMS);
  localparam int CNT_W = $clog2(MAX_ATOMS + 1);

  cnpf_pkg::state_t                 state_r;
  cnpf_pkg::state_t                 state_nxt;
  cnpf_pkg::axis_t                  axis_r;
  cnpf_pkg::axis_t                  axis_nxt;
  logic [CNT_W-1:0]                 count_r;
  logic [CNT_W-1:0]                 count_nxt;
  logic [IDX_W-1:0]                 me_r;
  logic [IDX_W-1:0]                 me_nxt;
  logic [IDX_W-1:0]                 idx_r;
  logic [IDX_W-1:0]                 idx_nxt;
  logic                             drop_r;
  logic                             drop_nxt;

  logic signed [COORD_BITS-1:0]     px_r;
  logic signed [COORD_BITS-1:0]     py_r;
  logic signed [COORD_BITS-1:0]     pz_r;

  logic [cnpf_pkg::LEN_W-1:0]       box_x_r;
  logic [cnpf_pkg::LEN_W-1:0]       box_y_r;
  logic [cnpf_pkg::LEN_W-1:0]       box_z_r;
  logic [cnpf_pkg::MASK_W-1:0]      pmask_r;
  logic [cnpf_pkg::LEN_W-1:0]       cutoff_r;

  logic                             out_valid_r;
  logic                             out_pair_valid_r;
  logic [cnpf_pkg::IDX_OUT_W-1:0]   out_lower_r;
  logic [cnpf_pkg::IDX_OUT_W-1:0]   out_upper_r;
  logic                             out_run_last_r;
  logic                             out_atom_dropped_r;

  logic                             out_load;
  logic                             ld_pair;
  logic [cnpf_pkg::IDX_OUT_W-1:0]   ld_lower;
  logic [cnpf_pkg::IDX_OUT_W-1:0]   ld_upper;
  logic                             ld_last;
  logic                             ld_drop;

  logic                             in_fire;
  logic                             out_free;
  logic [CNT_W-1:0]                 eff_cnt;
  logic                             full;
  logic                             mem_wr_en;
  logic [3*COORD_BITS-1:0]          rd_data;
  logic                             hit;
  cnpf_pkg::dp_ctrl_t               ctrl;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign eff_cnt  = in_chan.new_frame ? '0 : count_r;
  assign full     = (eff_cnt == CNT_W'(MAX_ATOMS));

  assign in_chan.ready = (state_r == cnpf_pkg::ST_IDLE);

  cnpf_store #(
    .DEPTH      (MAX_ATOMS),
    .COORD_BITS (COORD_BITS),
    .IDX_W      (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (eff_cnt[IDX_W-1:0]),
    .wr_data ({in_chan.pos_x, in_chan.pos_y, in_chan.pos_z}),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  cnpf_pair_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_pair_unit (
    .clk    (clk),
    .ctrl   (ctrl),
    .p_x    (px_r),
    .p_y    (py_r),
    .p_z    (pz_r),
    .s_x    (rd_data[3*COORD_BITS-1:2*COORD_BITS]),
    .s_y    (rd_data[2*COORD_BITS-1:COORD_BITS]),
    .s_z    (rd_data[COORD_BITS-1:0]),
    .box_x  (box_x_r),
    .box_y  (box_y_r),
    .box_z  (box_z_r),
    .pmask  (pmask_r),
    .cutoff (cutoff_r),
    .hit    (hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_x_r  <= '0;
      box_y_r  <= '0;
      box_z_r  <= '0;
      pmask_r  <= '0;
      cutoff_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cnpf_pkg::cfg_reg_t'(cfg_index))
        cnpf_pkg::REG_BOX_X:  box_x_r  <= cfg_wdata;
        cnpf_pkg::REG_BOX_Y:  box_y_r  <= cfg_wdata;
        cnpf_pkg::REG_BOX_Z:  box_z_r  <= cfg_wdata;
        cnpf_pkg::REG_PMASK:  pmask_r  <= cfg_wdata[cnpf_pkg::MASK_W-1:0];
        cnpf_pkg::REG_CUTOFF: cutoff_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cnpf_pkg::ST_IDLE;
      axis_r  <= cnpf_pkg::AXIS_X;
      count_r <= '0;
      me_r    <= '0;
      idx_r   <= '0;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      count_r <= count_nxt;
      me_r    <= me_nxt;
      idx_r   <= idx_nxt;
      drop_r  <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      px_r <= in_chan.pos_x;
      py_r <= in_chan.pos_y;
      pz_r <= in_chan.pos_z;
    end
  end

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    count_nxt = count_r;
    me_nxt    = me_r;
    idx_nxt   = idx_r;
    drop_nxt  = drop_r;
    mem_wr_en = 1'b0;
    ctrl      = '0;
    ctrl.axis = axis_r;
    out_load  = 1'b0;
    ld_pair   = 1'b0;
    ld_lower  = '0;
    ld_upper  = cnpf_pkg::IDX_OUT_W'(me_r);
    ld_last   = 1'b0;
    ld_drop   = 1'b0;

    unique case (state_r)
      cnpf_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (full) begin
            count_nxt = eff_cnt;
            drop_nxt  = 1'b1;
            state_nxt = cnpf_pkg::ST_DONE;
          end else begin
            mem_wr_en = 1'b1;
            count_nxt = CNT_W'(eff_cnt + 1'b1);
            me_nxt    = eff_cnt[IDX_W-1:0];
            idx_nxt   = '0;
            drop_nxt  = 1'b0;
            state_nxt = cnpf_pkg::ST_CUT;
          end
        end
      end
      cnpf_pkg::ST_CUT: begin
        ctrl.load_cut = 1'b1;
        state_nxt = (me_r == '0) ? cnpf_pkg::ST_DONE : cnpf_pkg::ST_RD;
      end
      cnpf_pkg::ST_RD: begin
        ctrl.clear = 1'b1;
        axis_nxt   = cnpf_pkg::AXIS_X;
        state_nxt  = cnpf_pkg::ST_DIF;
      end
      cnpf_pkg::ST_DIF: begin
        ctrl.dif  = 1'b1;
        state_nxt = cnpf_pkg::ST_WRP;
      end
      cnpf_pkg::ST_WRP: begin
        ctrl.wrp  = 1'b1;
        state_nxt = cnpf_pkg::ST_MAG;
      end
      cnpf_pkg::ST_MAG: begin
        ctrl.mag  = 1'b1;
        state_nxt = cnpf_pkg::ST_SQR;
      end
      cnpf_pkg::ST_SQR: begin
        ctrl.sqr  = 1'b1;
        state_nxt = cnpf_pkg::ST_ACC;
      end
      cnpf_pkg::ST_ACC: begin
        ctrl.acc = 1'b1;
        case (axis_r)
          cnpf_pkg::AXIS_X: axis_nxt = cnpf_pkg::AXIS_Y;
          cnpf_pkg::AXIS_Y: axis_nxt = cnpf_pkg::AXIS_Z;
          default:          axis_nxt = cnpf_pkg::AXIS_X;
        endcase
        state_nxt = (axis_r == cnpf_pkg::AXIS_Z) ? cnpf_pkg::ST_CMP : cnpf_pkg::ST_DIF;
      end
      cnpf_pkg::ST_CMP: begin
        // a hit waits here until the result register frees up
        if (!hit || out_free) begin
          out_load  = hit;
          ld_pair   = 1'b1;
          ld_lower  = cnpf_pkg::IDX_OUT_W'(idx_r);
          idx_nxt   = IDX_W'(idx_r + 1'b1);
          state_nxt = (IDX_W'(idx_r + 1'b1) == me_r) ? cnpf_pkg::ST_DONE : cnpf_pkg::ST_RD;
        end
      end
      cnpf_pkg::ST_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          ld_upper  = drop_r ? '0 : cnpf_pkg::IDX_OUT_W'(me_r);
          ld_last   = 1'b1;
          ld_drop   = drop_r;
          state_nxt = cnpf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cnpf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pair_valid_r   <= ld_pair;
      out_lower_r        <= ld_lower;
      out_upper_r        <= ld_upper;
      out_run_last_r     <= ld_last;
      out_atom_dropped_r <= ld_drop;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.pair_valid   = out_pair_valid_r;
  assign out_chan.lower_index  = out_lower_r;
  assign out_chan.upper_index  = out_upper_r;
  assign out_chan.run_last     = out_run_last_r;
  assign out_chan.atom_dropped = out_atom_dropped_r;

  `CNPF_ASSERT_IMPL(a_idx_below_me, (state_r == cnpf_pkg::ST_RD) || (state_r == cnpf_pkg::ST_CMP), idx_r < me_r)
  `CNPF_ASSERT_NEXT(a_close_ends_run, (state_r == cnpf_pkg::ST_DONE) && out_free, (state_r == cnpf_pkg::ST_IDLE) && out_valid_r && out_run_last_r)
  `CNPF_ASSERT_IMPL(a_drop_is_close, out_valid_r && out_atom_dropped_r, out_run_last_r && !out_pair_valid_r)
  `CNPF_ASSERT_NEXT(a_full_keeps_count, in_fire && full, (count_r == CNT_W'(MAX_ATOMS)) && drop_r)

endmodule

`default_nettype wire

[rtl/cnpf_store.sv]
// atom coordinate memory, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module cnpf_store #(
  parameter int DEPTH      = cnpf_pkg::DEF_MAX_ATOMS,
  parameter int COORD_BITS = cnpf_pkg::DEF_COORD_BITS,
  parameter int IDX_W      = $clog2(cnpf_pkg::DEF_MAX_ATOMS)
) (
  input  wire logic                    clk,
  input  wire logic                    wr_en,
  input  wire logic [IDX_W-1:0]        wr_addr,
  input  wire logic [3*COORD_BITS-1:0] wr_data,
  input  wire logic [IDX_W-1:0]        rd_addr,
  output logic      [3*COORD_BITS-1:0] rd_data
);

  logic [3*COORD_BITS-1:0] mem [DEPTH];
  logic [3*COORD_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[rtl/cnpf_pair_unit.sv]
// shared distance unit: difference, wrap, magnitude, one squaring multiplier
`timescale 1ns / 1ps
`default_nettype none

module cnpf_pair_unit #(
  parameter int COORD_BITS = cnpf_pkg::DEF_COORD_BITS
) (
  input  wire logic                              clk,
  input  wire cnpf_pkg::dp_ctrl_t                ctrl,
  input  wire logic signed [COORD_BITS-1:0]      p_x,
  input  wire logic signed [COORD_BITS-1:0]      p_y,
  input  wire logic signed [COORD_BITS-1:0]      p_z,
  input  wire logic signed [COORD_BITS-1:0]      s_x,
  input  wire logic signed [COORD_BITS-1:0]      s_y,
  input  wire logic signed [COORD_BITS-1:0]      s_z,
  input  wire logic [cnpf_pkg::LEN_W-1:0]        box_x,
  input  wire logic [cnpf_pkg::LEN_W-1:0]        box_y,
  input  wire logic [cnpf_pkg::LEN_W-1:0]        box_z,
  input  wire logic [cnpf_pkg::MASK_W-1:0]       pmask,
  input  wire logic [cnpf_pkg::LEN_W-1:0]        cutoff,
  output logic                                   hit
);

  localparam int DW = COORD_BITS + 1;
  localparam int WW = (COORD_BITS + 2 > cnpf_pkg::LEN_W + 2) ?
                      COORD_BITS + 2 : cnpf_pkg::LEN_W + 2;

  logic signed [COORD_BITS-1:0]     p_sel;
  logic signed [COORD_BITS-1:0]     s_sel;
  logic [cnpf_pkg::LEN_W-1:0]       len_sel;
  logic                             en_sel;

  logic signed [DW-1:0]             d_r;
  logic signed [DW-1:0]             d_nxt;
  logic signed [WW-1:0]             d_e;
  logic signed [WW-1:0]             l_e;
  logic signed [WW-1:0]             c_e;
  logic signed [WW-1:0]             twice;
  logic signed [WW-1:0]             w_r;
  logic signed [WW-1:0]             w_nxt;
  logic signed [WW-1:0]             mag_full;
  logic                             far_now;
  logic [cnpf_pkg::LEN_W-1:0]       mag_r;
  logic                             far_r;

  logic [cnpf_pkg::LEN_W-1:0]       mul_in;
  logic [cnpf_pkg::SQ_W-1:0]        mul_out;
  logic [cnpf_pkg::SQ_W-1:0]        prod_r;
  logic [cnpf_pkg::SQ_W-1:0]        cut2_r;
  logic [cnpf_pkg::ACC_W-1:0]       acc_r;

  always_comb begin
    case (ctrl.axis)
      cnpf_pkg::AXIS_Y: begin
        p_sel   = p_y;
        s_sel   = s_y;
        len_sel = box_y;
        en_sel  = pmask[1];
      end
      cnpf_pkg::AXIS_Z: begin
        p_sel   = p_z;
        s_sel   = s_z;
        len_sel = box_z;
        en_sel  = pmask[2];
      end
      default: begin
        p_sel   = p_x;
        s_sel   = s_x;
        len_sel = box_x;
        en_sel  = pmask[0];
      end
    endcase
  end

  assign d_nxt = DW'(p_sel) - DW'(s_sel);

  // single minimum-image wrap on the registered difference
  always_comb begin
    d_e   = WW'(d_r);
    l_e   = signed'(WW'(len_sel));
    twice = d_e <<< 1;
    w_nxt = d_e;
    if (en_sel && (len_sel != '0)) begin
      if (twice > l_e) begin
        w_nxt = d_e - l_e;
      end else if (twice < -l_e) begin
        w_nxt = d_e + l_e;
      end
    end
  end

  // magnitude and the early cutoff reject are computed side by side
  assign c_e      = signed'(WW'(cutoff));
  assign mag_full = w_r[WW-1] ? -w_r : w_r;
  assign far_now  = (w_r > c_e) || (w_r < -c_e);

  assign mul_in  = ctrl.load_cut ? cutoff : mag_r;
  assign mul_out = cnpf_pkg::SQ_W'(mul_in) * cnpf_pkg::SQ_W'(mul_in);

  always_ff @(posedge clk) begin
    if (ctrl.dif) begin
      d_r <= d_nxt;
    end
    if (ctrl.wrp) begin
      w_r <= w_nxt;
    end
    if (ctrl.mag) begin
      mag_r <= mag_full[cnpf_pkg::LEN_W-1:0];
    end
    if (ctrl.load_cut) begin
      cut2_r <= mul_out;
    end
    if (ctrl.sqr) begin
      prod_r <= mul_out;
    end
    if (ctrl.clear) begin
      acc_r <= '0;
      far_r <= 1'b0;
    end else begin
      if (ctrl.acc) begin
        acc_r <= acc_r + cnpf_pkg::ACC_W'(prod_r);
      end
      if (ctrl.mag) begin
        far_r <= far_r | far_now;
      end
    end
  end

  assign hit = !far_r && (acc_r <= cnpf_pkg::ACC_W'(cut2_r));

endmodule

`default_nettype wire
